[rtl/bole_pkg.sv]
// shared types and constants of the bounded ordered list engine
// request kinds, result status codes and the decoder plan struct
// no dependencies
package bole_pkg;

   // fixed field widths
   localparam int KindWidth    = 3;
   localparam int StatusWidth  = 3;
   localparam int WordWidth    = 32;
   localparam int PosWidth     = 6;
   localparam int CountWidth   = 6;
   localparam int ReqDataWidth = 40;
   localparam int RspDataWidth = 40;

   // request kinds
   typedef enum logic [KindWidth-1:0] {
      KIND_INS_END   = 3'd0,
      KIND_INS_FRONT = 3'd1,
      KIND_INS_AT    = 3'd2,
      KIND_DEL_FIRST = 3'd3,
      KIND_DEL_LAST  = 3'd4,
      KIND_DEL_AT    = 3'd5,
      KIND_DEL_VALUE = 3'd6,
      KIND_DUMP      = 3'd7
   } kind_type;

   // result status codes
   typedef enum logic [StatusWidth-1:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_BADPOS   = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   // what the sequencer has to do for one request
   typedef struct packed {
      logic       reject;
      status_type status;
      logic       grow;
      logic       scan;
      logic       dump;
   } plan_type;

endpackage

[rtl/bole_decode.sv]
// request decoder: checks a request against the current length
// and gives the move plan (first index, number of moves); uses bole_pkg
module bole_decode #(
   parameter int CAPACITY = 32
) (
   input  bole_pkg::kind_type                  kind,
   input  logic [bole_pkg::PosWidth-1:0]       position,
   input  logic [$clog2(CAPACITY+1)-1:0]       length,
   output bole_pkg::plan_type                  plan,
   output logic [$clog2(CAPACITY)-1:0]         index,
   output logic [$clog2(CAPACITY+1)-1:0]       moves
);

   localparam int AW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = ((LW > bole_pkg::PosWidth) ? LW : bole_pkg::PosWidth) + 1;

   logic [CW-1:0] len_w;
   logic [CW-1:0] pos_w;
   logic [CW-1:0] idx_w;
   logic [CW-1:0] mv_w;
   logic          full;
   logic          empty;

   assign len_w = CW'(length);
   assign pos_w = CW'(position);
   assign full  = (len_w == CW'(CAPACITY));
   assign empty = (len_w == '0);

   // range checks and move plan
   always_comb begin
      plan        = '0;
      plan.status = bole_pkg::ST_OK;
      idx_w       = '0;
      mv_w        = '0;
      case (kind)
         bole_pkg::KIND_INS_END: begin
            if (full) begin
               plan.reject = 1'b1;
               plan.status = bole_pkg::ST_FULL;
            end else begin
               plan.grow = 1'b1;
               idx_w     = len_w;
            end
         end
         bole_pkg::KIND_INS_FRONT: begin
            if (full) begin
               plan.reject = 1'b1;
               plan.status = bole_pkg::ST_FULL;
            end else begin
               plan.grow = 1'b1;
               mv_w      = len_w;
            end
         end
         bole_pkg::KIND_INS_AT: begin
            if (pos_w == '0 || pos_w > len_w + 1'b1) begin
               plan.reject = 1'b1;
               plan.status = bole_pkg::ST_BADPOS;
            end else if (full) begin
               plan.reject = 1'b1;
               plan.status = bole_pkg::ST_FULL;
            end else begin
               plan.grow = 1'b1;
               idx_w     = pos_w - 1'b1;
               mv_w      = len_w - pos_w + 1'b1;
            end
         end
         bole_pkg::KIND_DEL_FIRST: begin
            if (empty) begin
               plan.reject = 1'b1;
               plan.status = bole_pkg::ST_EMPTY;
            end else begin
               mv_w = len_w - 1'b1;
            end
         end
         bole_pkg::KIND_DEL_LAST: begin
            if (empty) begin
               plan.reject = 1'b1;
               plan.status = bole_pkg::ST_EMPTY;
            end else begin
               idx_w = len_w - 1'b1;
            end
         end
         bole_pkg::KIND_DEL_AT: begin
            if (empty) begin
               plan.reject = 1'b1;
               plan.status = bole_pkg::ST_EMPTY;
            end else if (pos_w == '0 || pos_w > len_w) begin
               plan.reject = 1'b1;
               plan.status = bole_pkg::ST_BADPOS;
            end else begin
               idx_w = pos_w - 1'b1;
               mv_w  = len_w - pos_w;
            end
         end
         bole_pkg::KIND_DEL_VALUE: begin
            if (empty) begin
               plan.reject = 1'b1;
               plan.status = bole_pkg::ST_EMPTY;
            end else begin
               plan.scan = 1'b1;
               mv_w      = len_w;
            end
         end
         bole_pkg::KIND_DUMP: begin
            if (empty) begin
               plan.reject = 1'b1;
               plan.status = bole_pkg::ST_EMPTY;
            end else begin
               plan.dump = 1'b1;
               mv_w      = len_w;
            end
         end
         default: begin
            plan.reject = 1'b1;
            plan.status = bole_pkg::ST_EMPTY;
         end
      endcase
   end

   assign index = idx_w[AW-1:0];
   assign moves = mv_w[LW-1:0];

endmodule

[rtl/bounded_ordered_list_engine_unit.sv]
// top level of the bounded ordered list engine: sequencer, list memory, result register
// uses bole_pkg and bole_decode
//
// Holds an ordered list of up to CAPACITY signed 32-bit words.
// req channel: one word per request, kind in req_tuser, value and position in req_tdata.
//   A word is taken when req_tvalid and req_tready are high; req_tready is high only
//   while the sequencer is idle, so one request is worked on at a time.
// rsp channel: every request gives one result word with tlast high, except a dump,
//   which gives one word per element in list order, tlast on the final one
//   (an empty dump gives a single word with status empty).
// Memory: all list data sits in one single-port-read, single-port-write memory with a
//   registered read, and one step unit walks the index one entry at a time.
//   Positional inserts and deletes shift the entries behind the position one place over,
//   at most CAPACITY - 1 of them; delete by value scans from index 0 up to the first
//   match and then shifts the tail down, or gives status not found when it is absent.
//   A dump reads and sends each element in turn; a rejected request goes straight to its result.
// A finished result waits in the output register while the next request is taken;
// a stalled receiver holds the sequencer only when a new result has to be loaded.
// Reset empties the list at once (length cleared); no memory clearing pass is needed.
module bounded_ordered_list_engine_unit #(
   parameter int CAPACITY = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // value [31:0], position [37:32], zero [39:38]
   input  logic [bole_pkg::ReqDataWidth-1:0]    req_tdata,
   // kind [2:0]
   input  logic [bole_pkg::KindWidth-1:0]       req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // element [31:0], count [37:32], zero [39:38]
   output logic [bole_pkg::RspDataWidth-1:0]    rsp_tdata,
   // status [2:0]
   output logic [bole_pkg::StatusWidth-1:0]     rsp_tuser,
   output logic                                 rsp_tlast
);

   localparam int AW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = ((LW > bole_pkg::CountWidth) ? LW : bole_pkg::CountWidth) + 1;
   localparam int WW = bole_pkg::WordWidth;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOVE,
      S_SCAN,
      S_RESP,
      S_DUMP_RD,
      S_DUMP_WR
   } state_type;

   state_type                     state_ff, state_in;
   logic [LW-1:0]                 length_ff, length_in;
   logic [WW-1:0]                 value_ff, value_in;
   logic [AW-1:0]                 index_ff, index_in;
   logic [LW-1:0]                 remain_ff, remain_in;
   logic [AW-1:0]                 src_ff, src_in;
   logic                          grow_ff, grow_in;
   bole_pkg::status_type          status_ff, status_in;
   logic                          rd_pend_ff, rd_pend_in;
   logic [AW-1:0]                 rd_addr_ff, rd_addr_in;
   logic [WW-1:0]                 rd_data_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   bole_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [WW-1:0]                 rsp_element_ff, rsp_element_in;
   logic [bole_pkg::CountWidth-1:0] rsp_count_ff, rsp_count_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   logic [WW-1:0]                 wr_data;
   logic                          rd_en;
   logic [AW-1:0]                 rd_addr;
   logic [AW-1:0]                 step;
   logic [AW-1:0]                 dst;
   logic                          slot_free;
   logic                          req_accept;
   logic [CW-1:0]                 len_ext;
   logic [bole_pkg::CountWidth-1:0] count_now;

   bole_pkg::plan_type            plan;
   logic [AW-1:0]                 dec_index;
   logic [LW-1:0]                 dec_moves;

   logic [WW-1:0]                 mem [CAPACITY];

   // request decode
   bole_decode #(
      .CAPACITY (CAPACITY)
   ) u_decode (
      .kind     (bole_pkg::kind_type'(req_tuser)),
      .position (req_tdata[WW +: bole_pkg::PosWidth]),
      .length   (length_ff),
      .plan     (plan),
      .index    (dec_index),
      .moves    (dec_moves)
   );

   // shared index step unit: down for inserts, up for deletes, scans and dumps
   assign step = grow_ff ? (src_ff - 1'b1) : (src_ff + 1'b1);
   assign dst  = grow_ff ? (rd_addr_ff + 1'b1) : (rd_addr_ff - 1'b1);

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign len_ext    = CW'(length_ff);
   assign count_now  = len_ext[bole_pkg::CountWidth-1:0];

   // sequencer next state
   always_comb begin
      state_in       = state_ff;
      length_in      = length_ff;
      value_in       = value_ff;
      index_in       = index_ff;
      remain_in      = remain_ff;
      src_in         = src_ff;
      grow_in        = grow_ff;
      status_in      = status_ff;
      rd_pend_in     = 1'b0;
      rd_addr_in     = rd_addr_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_last_in    = rsp_last_ff;
      wr_en          = 1'b0;
      wr_addr        = dst;
      wr_data        = rd_data_ff;
      rd_en          = 1'b0;
      rd_addr        = src_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               value_in  = req_tdata[WW-1:0];
               status_in = plan.status;
               index_in  = dec_index;
               remain_in = dec_moves;
               grow_in   = plan.grow;
               if (plan.reject) begin
                  state_in = S_RESP;
               end else if (plan.dump) begin
                  src_in   = '0;
                  state_in = S_DUMP_RD;
               end else if (plan.scan) begin
                  src_in   = '0;
                  state_in = S_SCAN;
               end else if (plan.grow) begin
                  src_in   = AW'(length_ff - 1'b1);
                  state_in = S_MOVE;
               end else begin
                  src_in   = dec_index + 1'b1;
                  state_in = S_MOVE;
               end
            end
         end
         S_MOVE: begin
            // write back the word read in the previous cycle one place over
            if (rd_pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = dst;
               wr_data = rd_data_ff;
            end
            if (remain_ff != '0) begin
               rd_en      = 1'b1;
               rd_addr    = src_ff;
               rd_pend_in = 1'b1;
               rd_addr_in = src_ff;
               src_in     = step;
               remain_in  = remain_ff - 1'b1;
            end else if (!rd_pend_ff) begin
               if (grow_ff) begin
                  wr_en     = 1'b1;
                  wr_addr   = index_ff;
                  wr_data   = value_ff;
                  length_in = length_ff + 1'b1;
               end else begin
                  length_in = length_ff - 1'b1;
               end
               state_in = S_RESP;
            end
         end
         S_SCAN: begin
            if (rd_pend_ff && rd_data_ff == value_ff) begin
               // first match: remove it by shifting the tail down
               index_in  = rd_addr_ff;
               remain_in = LW'(length_ff - LW'(rd_addr_ff) - 1'b1);
               src_in    = rd_addr_ff + 1'b1;
               grow_in   = 1'b0;
               status_in = bole_pkg::ST_OK;
               state_in  = S_MOVE;
            end else if (remain_ff != '0) begin
               rd_en      = 1'b1;
               rd_addr    = src_ff;
               rd_pend_in = 1'b1;
               rd_addr_in = src_ff;
               src_in     = step;
               remain_in  = remain_ff - 1'b1;
            end else if (!rd_pend_ff) begin
               status_in = bole_pkg::ST_NOTFOUND;
               state_in  = S_RESP;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_element_in = '0;
               rsp_count_in   = count_now;
               rsp_last_in    = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_DUMP_RD: begin
            rd_en    = 1'b1;
            rd_addr  = src_ff;
            state_in = S_DUMP_WR;
         end
         S_DUMP_WR: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = bole_pkg::ST_OK;
               rsp_element_in = rd_data_ff;
               rsp_count_in   = count_now;
               rsp_last_in    = (LW'(src_ff) + 1'b1 == length_ff);
               if (LW'(src_ff) + 1'b1 == length_ff) begin
                  state_in = S_IDLE;
               end else begin
                  src_in   = step;
                  state_in = S_DUMP_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         length_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff       <= value_in;
      index_ff       <= index_in;
      remain_ff      <= remain_in;
      src_ff         <= src_in;
      grow_ff        <= grow_in;
      status_ff      <= status_in;
      rd_addr_ff     <= rd_addr_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // list memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(bole_pkg::RspDataWidth - WW - bole_pkg::CountWidth){1'b0}},
                        rsp_count_ff, rsp_element_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      length_ff <= LW'(CAPACITY))
      else $error("list length above capacity");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("request taken while a request is in work");

   a_length_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (length_ff == $past(length_ff) || length_ff == $past(length_ff) + 1'b1
                || length_ff + 1'b1 == $past(length_ff)))
      else $error("length moved by more than one");

   a_open_word_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tuser == bole_pkg::ST_OK))
      else $error("non-final result word with error status");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (LW'(wr_addr) < LW'(CAPACITY)))
      else $error("memory write beyond capacity");
`endif

endmodule
